[src/mcdma_pkg.sv]
// Package: shared types, codes and constants of the multi-channel DMA controller.
package mcdma_pkg;

  localparam int DEF_NUM_CHANNELS = 7;
  localparam int DEF_GPU_CHANNEL  = 2;
  localparam int DEF_OTC_CHANNEL  = 6;

  // input commands
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_ADVANCE = 2'd2;
  localparam logic [1:0] CMD_DATA    = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_ACK   = 3'd0;
  localparam logic [2:0] KIND_READ  = 3'd1;
  localparam logic [2:0] KIND_LOAD  = 3'd2;
  localparam logic [2:0] KIND_STORE = 3'd3;
  localparam logic [2:0] KIND_GPU   = 3'd4;
  localparam logic [2:0] KIND_DONE  = 3'd5;

  // transfer phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ISSUE = 2'd1;
  localparam logic [1:0] PH_WORD  = 2'd2;
  localparam logic [1:0] PH_HDR   = 2'd3;

  // register indexes
  localparam logic [4:0] IDX_PRIORITY = 5'd28;
  localparam logic [4:0] IDX_IRQ      = 5'd29;
  localparam logic [1:0] REG_ADDR     = 2'd0;
  localparam logic [1:0] REG_BLOCK    = 2'd1;
  localparam logic [1:0] REG_CTRL     = 2'd2;

  localparam logic [31:0] ADDR_MASK     = 32'h001F_FFFC;
  localparam logic [31:0] CTRL_MASK     = 32'h7177_0703;
  localparam logic [31:0] PRIORITY_INIT = 32'h0765_4321;
  localparam logic [31:0] OTC_END       = 32'hFFFF_FFFF;
  localparam logic [31:0] LINK_MASK     = 32'h001F_FFFF;
  localparam logic [31:0] LIST_END_BIT  = 32'h0080_0000;
  localparam logic [31:0] GPU_READ_PORT = 32'h1F80_1810;
  localparam logic [31:0] IRQ_HI_MASK   = 32'h00FF_8000;
  localparam logic [31:0] IRQ_LO_MASK   = 32'h0000_003F;

  localparam int QUEUE_DEPTH = 2;

  // one result item
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] read_data;
    logic [31:0] mem_address;
    logic [31:0] word_out;
    logic [2:0]  channel_num;
    logic        last;
  } result_t;

  // item classified by the front end
  typedef struct packed {
    logic [1:0]  command;
    logic [4:0]  reg_index;
    logic [31:0] write_data;
    logic [31:0] load_data;
  } item_t;

endpackage

[src/mcdma_queue.sv]
// Small FIFO between the front end and the transfer engine.
module mcdma_queue import mcdma_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  item_t wr_item,
  output logic  rd_valid,
  input  logic  rd_ready,
  output item_t rd_item
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t            mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;
  logic             do_wr, do_rd;

  assign wr_ready = (cnt_r != AW'(0) + (AW+1)'(DEPTH)) || (rd_ready && rd_valid);
  assign rd_valid = (cnt_r != '0);
  assign rd_item  = mem_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // pointer and count update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (do_rd) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_item;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (AW+1)'(DEPTH)) else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> !do_rd) else $error("queue underflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (do_wr && !do_rd) |=> (cnt_r == $past(cnt_r) + 1'b1)) else $error("count slip");
endmodule

[src/mcdma_engine.sv]
// Transfer engine: register file, channel selection and word sequencing.
module mcdma_engine import mcdma_pkg::*; #(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int GPU_CHANNEL  = DEF_GPU_CHANNEL,
  parameter int OTC_CHANNEL  = DEF_OTC_CHANNEL
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    it_valid,
  output logic    it_ready,
  input  item_t   it,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);
  // one item yields at most two results; they are kept in a small buffer
  result_t          buf_r [3];
  result_t          buf_nxt [3];
  logic [1:0]       cnt_r, cnt_nxt;
  logic [1:0]       pos_r;

  logic [31:0]      regs_r [28];
  logic [31:0]      prio_r, irq_r;
  logic [2:0]       act_r;
  logic [31:0]      addr_r, left_r, hdr_r;
  logic [7:0]       pkt_r;
  logic [1:0]       phase_r;
  logic [1:0]       mode_r;
  logic             dir_r, down_r;

  logic [31:0]      regs_nxt [28];
  logic [31:0]      prio_nxt, irq_nxt;
  logic [2:0]       act_nxt;
  logic [31:0]      addr_nxt, left_nxt, hdr_nxt;
  logic [7:0]       pkt_nxt;
  logic [1:0]       phase_nxt, mode_nxt;
  logic             dir_nxt, down_nxt;

  logic             take;
  logic             drained;

  // control and block words of the selected channel
  logic [31:0]      sel_ctrl, sel_blk;
  logic [2:0]       sel_ch;
  logic             sel_ok;

  assign drained   = (cnt_r == '0) || ((pos_r == cnt_r - 2'd1) && out_ready);
  assign it_ready  = drained;
  assign take      = it_valid && it_ready;
  assign out_valid = (cnt_r != '0);
  assign out_res   = buf_r[pos_r];

  // lowest enabled, ready channel
  always_comb begin
    sel_ok   = 1'b0;
    sel_ch   = '0;
    sel_ctrl = '0;
    sel_blk  = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (regs_r[i*4+2][24] && (regs_r[i*4+2][28] || regs_r[i*4+2][10:9] != 2'd0)) begin
        sel_ok   = 1'b1;
        sel_ch   = 3'(i);
        sel_ctrl = regs_r[i*4+2];
        sel_blk  = regs_r[i*4+1];
      end
    end
  end

  // next-state for one item
  always_comb begin
    logic [31:0] v;
    logic [4:0]  ci;
    logic [1:0]  n;
    logic        fin;
    logic        iss;
    regs_nxt  = regs_r;
    prio_nxt  = prio_r;
    irq_nxt   = irq_r;
    act_nxt   = act_r;
    addr_nxt  = addr_r;
    left_nxt  = left_r;
    hdr_nxt   = hdr_r;
    pkt_nxt   = pkt_r;
    phase_nxt = phase_r;
    mode_nxt  = mode_r;
    dir_nxt   = dir_r;
    down_nxt  = down_r;
    buf_nxt   = buf_r;
    n         = '0;
    fin       = 1'b0;
    iss       = 1'b0;
    v         = '0;
    ci        = '0;
    for (int k = 0; k < 3; k++) buf_nxt[k] = '0;

    unique case (it.command)
      CMD_WRITE: begin
        if (it.reg_index < IDX_PRIORITY) begin
          v = it.write_data;
          if (it.reg_index[1:0] == REG_ADDR) v = v & ADDR_MASK;
          else if (it.reg_index[1:0] == REG_CTRL) v = v & CTRL_MASK;
          regs_nxt[it.reg_index] = v;
        end else if (it.reg_index == IDX_PRIORITY) begin
          prio_nxt = it.write_data;
        end else if (it.reg_index == IDX_IRQ) begin
          v = it.write_data & (IRQ_LO_MASK | IRQ_HI_MASK);
          irq_nxt = {v[15], v[30:0]};
        end
      end
      CMD_READ: begin
        if (it.reg_index < IDX_PRIORITY) v = regs_r[it.reg_index];
        else if (it.reg_index == IDX_PRIORITY) v = prio_r;
        else if (it.reg_index == IDX_IRQ) v = irq_r;
        buf_nxt[0].kind      = KIND_READ;
        buf_nxt[0].read_data = v;
        n = 2'd1;
      end
      CMD_ADVANCE: begin
        if (phase_r == PH_ISSUE) begin
          iss = 1'b1;
        end else if (phase_r == PH_IDLE && sel_ok) begin
          act_nxt  = sel_ch;
          mode_nxt = sel_ctrl[10:9];
          dir_nxt  = sel_ctrl[0];
          down_nxt = sel_ctrl[1];
          addr_nxt = regs_r[{sel_ch, 2'b00}];
          pkt_nxt  = '0;
          hdr_nxt  = '0;
          if (sel_ctrl[10:9] == 2'd0) left_nxt = {16'd0, sel_blk[15:0]};
          else left_nxt = sel_blk[15:0] * sel_blk[31:16];
          if (sel_ctrl[10:9] == 2'd3) fin = 1'b1;
          else iss = 1'b1;
        end
        // issue the next operation from the latched transfer values
        if (iss) begin
          phase_nxt = PH_ISSUE;
          if (mode_nxt == 2'd2) begin
            if (pkt_nxt != 8'd0) begin
              addr_nxt = (addr_nxt + 32'd4) & ADDR_MASK;
              phase_nxt = PH_WORD;
            end else begin
              phase_nxt = PH_HDR;
            end
            buf_nxt[0].kind        = KIND_LOAD;
            buf_nxt[0].mem_address = addr_nxt;
            buf_nxt[0].channel_num = act_nxt;
            n = 2'd1;
          end else if (left_nxt == '0) begin
            fin = 1'b1;
          end else if (!dir_nxt && act_nxt == 3'(OTC_CHANNEL)) begin
            buf_nxt[0].kind        = KIND_STORE;
            buf_nxt[0].mem_address = addr_nxt;
            buf_nxt[0].word_out    = (left_nxt == 32'd1) ? OTC_END :
                                     ((addr_nxt - 32'd4) & LINK_MASK);
            buf_nxt[0].channel_num = act_nxt;
            n = 2'd1;
            addr_nxt = down_nxt ? addr_nxt - 32'd4 : addr_nxt + 32'd4;
            left_nxt = left_nxt - 32'd1;
            fin = (left_nxt == '0);
          end else if (!dir_nxt && act_nxt != 3'(GPU_CHANNEL)) begin
            buf_nxt[0].kind        = KIND_STORE;
            buf_nxt[0].mem_address = addr_nxt;
            buf_nxt[0].channel_num = act_nxt;
            n = 2'd1;
            addr_nxt = down_nxt ? addr_nxt - 32'd4 : addr_nxt + 32'd4;
            left_nxt = left_nxt - 32'd1;
            fin = (left_nxt == '0);
          end else begin
            buf_nxt[0].kind        = KIND_LOAD;
            buf_nxt[0].mem_address = dir_nxt ? addr_nxt : GPU_READ_PORT;
            buf_nxt[0].channel_num = act_nxt;
            n = 2'd1;
            phase_nxt = PH_WORD;
          end
        end
      end
      CMD_DATA: begin
        if (phase_r == PH_HDR) begin
          hdr_nxt = it.load_data;
          pkt_nxt = it.load_data[31:24];
          if (pkt_nxt == 8'd0) begin
            if (hdr_nxt[23]) fin = 1'b1;
            else begin
              addr_nxt = hdr_nxt & ADDR_MASK;
              phase_nxt = PH_ISSUE;
            end
          end else phase_nxt = PH_ISSUE;
        end else if (phase_r == PH_WORD) begin
          if (mode_r == 2'd2) begin
            buf_nxt[0].kind        = KIND_GPU;
            buf_nxt[0].word_out    = it.load_data;
            buf_nxt[0].channel_num = act_r;
            n = 2'd1;
            pkt_nxt = pkt_r - 8'd1;
            if (pkt_nxt == 8'd0) begin
              if (hdr_r[23]) fin = 1'b1;
              else begin
                addr_nxt = hdr_r & ADDR_MASK;
                phase_nxt = PH_ISSUE;
              end
            end else phase_nxt = PH_ISSUE;
          end else begin
            if (!dir_r) begin
              buf_nxt[0].kind        = KIND_STORE;
              buf_nxt[0].mem_address = addr_r;
              buf_nxt[0].word_out    = it.load_data;
              buf_nxt[0].channel_num = act_r;
              n = 2'd1;
            end else if (act_r == 3'(GPU_CHANNEL)) begin
              buf_nxt[0].kind        = KIND_GPU;
              buf_nxt[0].word_out    = it.load_data;
              buf_nxt[0].channel_num = act_r;
              n = 2'd1;
            end
            addr_nxt = down_r ? addr_r - 32'd4 : addr_r + 32'd4;
            left_nxt = left_r - 32'd1;
            if (left_nxt == '0) fin = 1'b1;
            else phase_nxt = PH_ISSUE;
          end
        end
      end
      default: ;
    endcase

    // channel completion
    if (fin) begin
      ci = {act_nxt, REG_CTRL};
      regs_nxt[ci][24] = 1'b0;
      regs_nxt[ci][28] = 1'b0;
      buf_nxt[n].kind        = KIND_DONE;
      buf_nxt[n].channel_num = act_nxt;
      n = n + 2'd1;
      phase_nxt = PH_IDLE;
    end
    if (n == 2'd0) begin
      buf_nxt[0].kind = KIND_ACK;
      n = 2'd1;
    end
    buf_nxt[n-2'd1].last = 1'b1;
    cnt_nxt = n;
  end

  // state and result buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 28; k++) regs_r[k] <= '0;
      prio_r  <= PRIORITY_INIT;
      irq_r   <= '0;
      act_r   <= '0;
      addr_r  <= '0;
      left_r  <= '0;
      hdr_r   <= '0;
      pkt_r   <= '0;
      phase_r <= PH_IDLE;
      mode_r  <= '0;
      dir_r   <= 1'b0;
      down_r  <= 1'b0;
      cnt_r   <= '0;
      pos_r   <= '0;
    end else if (take) begin
      regs_r  <= regs_nxt;
      prio_r  <= prio_nxt;
      irq_r   <= irq_nxt;
      act_r   <= act_nxt;
      addr_r  <= addr_nxt;
      left_r  <= left_nxt;
      hdr_r   <= hdr_nxt;
      pkt_r   <= pkt_nxt;
      phase_r <= phase_nxt;
      mode_r  <= mode_nxt;
      dir_r   <= dir_nxt;
      down_r  <= down_nxt;
      buf_r   <= buf_nxt;
      cnt_r   <= cnt_nxt;
      pos_r   <= '0;
    end else if (out_valid && out_ready) begin
      if (pos_r == cnt_r - 2'd1) cnt_r <= '0;
      else pos_r <= pos_r + 2'd1;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pos_r < cnt_r)) else $error("result pointer past end");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (pos_r == cnt_r - 2'd1)) |-> out_res.last) else $error("missing last");
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (act_r < 3'(NUM_CHANNELS) || act_r == '0))
    else $error("bad active channel");
endmodule

[src/mcdma_front.sv]
// Front end: accepts items and classifies them into the queue.
module mcdma_front import mcdma_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [4:0]  in_reg_index,
  input  logic [31:0] in_write_data,
  input  logic [31:0] in_load_data,
  output logic        q_valid,
  input  logic        q_ready,
  output item_t       q_item
);
  // skid register so the input side sees a registered ready
  logic  full_r;
  item_t hold_r;

  assign in_ready = !full_r;
  assign q_valid  = full_r || in_valid;
  assign q_item   = full_r ? hold_r :
                    item_t'{command: in_command, reg_index: in_reg_index,
                      write_data: (in_command == CMD_WRITE) ? in_write_data : '0,
                      load_data: (in_command == CMD_DATA) ? in_load_data : '0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (full_r) begin
      if (q_ready) full_r <= 1'b0;
    end else if (in_valid && !q_ready) begin
      full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!full_r) hold_r <= q_item;
  end
endmodule

[src/multi_channel_dma_controller.sv]
// Top level of the multi-channel DMA controller.
// Each item (register write, register read, advance, or returning load data) is
// accepted and yields one or two result items, delivered one per cycle while
// out_ready is high; the next item enters as the last result of the previous
// one leaves, so an item that yields one result sustains one item per cycle
// while out_ready is high. A skid stage and a two-entry queue separate the input
// port from the transfer engine; the result buffer of the engine sets the rate.
module multi_channel_dma_controller import mcdma_pkg::*; #(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int GPU_CHANNEL  = DEF_GPU_CHANNEL,
  parameter int OTC_CHANNEL  = DEF_OTC_CHANNEL
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [4:0]  in_reg_index,
  input  logic [31:0] in_write_data,
  input  logic [31:0] in_load_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [31:0] out_read_data,
  output logic [31:0] out_mem_address,
  output logic [31:0] out_word_out,
  output logic [2:0]  out_channel_num,
  output logic        out_last
);
  logic    f_valid, f_ready, e_valid, e_ready;
  item_t   f_item, e_item;
  result_t res;

  mcdma_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_command, .in_reg_index,
    .in_write_data, .in_load_data,
    .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item)
  );

  mcdma_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
    .rd_valid(e_valid), .rd_ready(e_ready), .rd_item(e_item)
  );

  mcdma_engine #(
    .NUM_CHANNELS(NUM_CHANNELS), .GPU_CHANNEL(GPU_CHANNEL), .OTC_CHANNEL(OTC_CHANNEL)
  ) u_engine (
    .clk, .rst_n, .it_valid(e_valid), .it_ready(e_ready), .it(e_item),
    .out_valid, .out_ready, .out_res(res)
  );

  assign out_kind        = res.kind;
  assign out_read_data   = res.read_data;
  assign out_mem_address = res.mem_address;
  assign out_word_out    = res.word_out;
  assign out_channel_num = res.channel_num;
  assign out_last        = res.last;
endmodule

[tb/sv/multi_channel_dma_controller_tb.sv]
// Testbench for the multi-channel DMA controller: register access, transfers, scoreboard.
`timescale 1ns / 100ps

module multi_channel_dma_controller_tb;
  import mcdma_pkg::*;

  localparam int NCH = DEF_NUM_CHANNELS;
  localparam int GPU_CH = DEF_GPU_CHANNEL;
  localparam int OTC_CH = DEF_OTC_CHANNEL;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEM_TARGET = 390;

  // mode codes of the control register
  localparam logic [1:0] MODE_BLOCK = 2'd0;
  localparam logic [1:0] MODE_SYNC  = 2'd1;
  localparam logic [1:0] MODE_LIST  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;
  localparam logic [31:0] CTRL_EN   = 32'h0100_0000;
  localparam logic [31:0] CTRL_TRIG = 32'h1000_0000;

  // scoreboard: shadow of the DMA state, queue of expected result items
  class dma_scoreboard;
    logic [31:0] regs [28];
    logic [31:0] prio_word, irq_word;
    logic [2:0]  act_ch;
    logic [31:0] cur_addr, words_left, list_hdr;
    logic [7:0]  pkt_left;
    logic [1:0]  phase, l_mode;
    logic        l_dir, l_down;
    result_t     pending[$];
    int          mismatches;

    function void reset_state();
      foreach (regs[i]) regs[i] = '0;
      prio_word = PRIORITY_INIT; irq_word = '0; act_ch = '0;
      cur_addr = '0; words_left = '0; list_hdr = '0; pkt_left = '0;
      phase = PH_IDLE; l_mode = '0; l_dir = 1'b0; l_down = 1'b0;
      pending.delete(); mismatches = 0;
    endfunction

    function void push(logic [2:0] k, logic [31:0] rd, logic [31:0] a,
                       logic [31:0] w, logic [2:0] ch);
      result_t r;
      r = '{kind: k, read_data: rd, mem_address: a, word_out: w, channel_num: ch,
            last: 1'b0};
      pending.push_back(r);
    endfunction

    function void complete();
      regs[act_ch*4+2] &= ~(CTRL_EN | CTRL_TRIG);
      push(KIND_DONE, 0, 0, 0, act_ch);
      phase = PH_IDLE;
    endfunction

    function void next_word();
      cur_addr += l_down ? 32'hFFFF_FFFC : 32'd4;
      words_left--;
      if (words_left == 0) complete();
      else phase = PH_ISSUE;
    endfunction

    function void packet_end();
      if (list_hdr & LIST_END_BIT) complete();
      else begin
        cur_addr = list_hdr & ADDR_MASK;
        phase = PH_ISSUE;
      end
    endfunction

    function void issue_op();
      if (l_mode == MODE_LIST) begin
        if (pkt_left > 0) begin
          cur_addr = (cur_addr + 4) & ADDR_MASK;
          push(KIND_LOAD, 0, cur_addr, 0, act_ch);
          phase = PH_WORD;
        end else begin
          push(KIND_LOAD, 0, cur_addr, 0, act_ch);
          phase = PH_HDR;
        end
      end else if (words_left == 0) complete();
      else if (l_dir == 1'b0) begin
        if (act_ch == OTC_CH) begin
          push(KIND_STORE, 0, cur_addr,
               (words_left == 1) ? OTC_END : ((cur_addr - 4) & LINK_MASK), act_ch);
          next_word();
        end else if (act_ch == GPU_CH) begin
          push(KIND_LOAD, 0, GPU_READ_PORT, 0, act_ch);
          phase = PH_WORD;
        end else begin
          push(KIND_STORE, 0, cur_addr, 0, act_ch);
          next_word();
        end
      end else begin
        push(KIND_LOAD, 0, cur_addr, 0, act_ch);
        phase = PH_WORD;
      end
    endfunction

    function void advance();
      logic [31:0] c, blk;
      if (phase == PH_ISSUE) begin
        issue_op();
        return;
      end
      if (phase != PH_IDLE) return;
      for (int i = 0; i < NCH; i++) begin
        c = regs[i*4+2];
        if (c[24] && (c[28] || c[10:9] != MODE_BLOCK)) begin
          blk = regs[i*4+1];
          act_ch = i[2:0]; l_mode = c[10:9]; l_dir = c[0]; l_down = c[1];
          cur_addr = regs[i*4]; pkt_left = '0; list_hdr = '0;
          words_left = (l_mode == MODE_BLOCK) ? {16'd0, blk[15:0]}
                                              : blk[15:0] * blk[31:16];
          if (l_mode == MODE_NONE) begin
            complete();
            return;
          end
          phase = PH_ISSUE;
          issue_op();
          return;
        end
      end
    endfunction

    function void data_in(logic [31:0] d);
      if (phase == PH_HDR) begin
        list_hdr = d; pkt_left = d[31:24];
        if (pkt_left == 0) packet_end();
        else phase = PH_ISSUE;
      end else if (phase == PH_WORD) begin
        if (l_mode == MODE_LIST) begin
          push(KIND_GPU, 0, 0, d, act_ch);
          pkt_left--;
          if (pkt_left == 0) packet_end();
          else phase = PH_ISSUE;
        end else if (l_dir == 1'b0) begin
          push(KIND_STORE, 0, cur_addr, d, act_ch);
          next_word();
        end else begin
          if (act_ch == GPU_CH) push(KIND_GPU, 0, 0, d, act_ch);
          next_word();
        end
      end
    endfunction

    // note an accepted input item and queue what it should produce
    function void note_input(logic [1:0] cmd, logic [4:0] idx, logic [31:0] wd,
                             logic [31:0] ld);
      int n0;
      logic [31:0] v;
      n0 = pending.size();
      case (cmd)
        CMD_WRITE: begin
          if (idx < IDX_PRIORITY) begin
            if (idx[1:0] == REG_ADDR) regs[idx] = wd & ADDR_MASK;
            else if (idx[1:0] == REG_CTRL) regs[idx] = wd & CTRL_MASK;
            else regs[idx] = wd;
          end else if (idx == IDX_PRIORITY) prio_word = wd;
          else if (idx == IDX_IRQ) begin
            v = (wd & IRQ_LO_MASK) | (wd & IRQ_HI_MASK);
            v[31] = v[15];
            irq_word = v;
          end
        end
        CMD_READ: begin
          v = '0;
          if (idx < IDX_PRIORITY) v = regs[idx];
          else if (idx == IDX_PRIORITY) v = prio_word;
          else if (idx == IDX_IRQ) v = irq_word;
          push(KIND_READ, v, 0, 0, 0);
        end
        CMD_ADVANCE: advance();
        default: data_in(ld);
      endcase
      if (pending.size() == n0) push(KIND_ACK, 0, 0, 0, 0);
      pending[pending.size()-1].last = 1'b1;
    endfunction

    // compare one result item with the oldest expectation
    function void check_result(result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_r, got);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = '0;
  logic [4:0]  in_reg_index = '0;
  logic [31:0] in_write_data = '0;
  logic [31:0] in_load_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [31:0] out_read_data, out_mem_address, out_word_out;
  logic [2:0]  out_channel_num;
  logic        out_last;

  dma_scoreboard sb;
  int idle_cycles = 0;
  int burst_left = 0;
  int items_sent = 0;
  bit stall_on = 1'b1;

  always #2 clk = ~clk;

  multi_channel_dma_controller dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_command(in_command),
    .in_reg_index(in_reg_index), .in_write_data(in_write_data),
    .in_load_data(in_load_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_read_data(out_read_data), .out_mem_address(out_mem_address),
    .out_word_out(out_word_out), .out_channel_num(out_channel_num),
    .out_last(out_last)
  );

  // result side: check accepted items, stall in runs
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{kind: out_kind, read_data: out_read_data,
                        mem_address: out_mem_address, word_out: out_word_out,
                        channel_num: out_channel_num, last: out_last});
    if ($urandom_range(0, 31) == 0) stall_on <= ~stall_on;
    out_ready <= stall_on ? ($urandom_range(0, 2) != 0) : 1'b1;
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // send one item, with a burst-and-gap pattern ahead of it
  task automatic send_item(logic [1:0] cmd, logic [4:0] idx, logic [31:0] wd,
                           logic [31:0] ld);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      // valid drops only for a real gap between bursts
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_command <= cmd; in_reg_index <= idx; in_write_data <= wd; in_load_data <= ld;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(cmd, idx, wd, ld);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0] ctrl_word(logic [1:0] mode, bit dir, bit down, bit trig);
    return CTRL_EN | (trig ? CTRL_TRIG : 32'd0) | {21'd0, mode, 7'd0, down, dir};
  endfunction

  // a random transfer on one channel, answering loads with data
  task automatic run_transfer(int ch);
    logic [1:0] mode;
    logic [31:0] blk;
    int steps;
    mode = 2'($urandom_range(0, 3));
    blk = (mode == MODE_BLOCK) ? $urandom_range(0, 5)
                               : {16'($urandom_range(0, 3)), 16'($urandom_range(0, 3))};
    send_item(CMD_WRITE, 5'(ch*4), $urandom, 0);
    send_item(CMD_WRITE, 5'(ch*4+1), blk, 0);
    send_item(CMD_WRITE, 5'(ch*4+2), ctrl_word(mode, 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))) |
              ($urandom & 32'h0006_0000), 0);
    steps = 0;
    while (steps < 40) begin
      steps++;
      if (sb.phase == PH_WORD || sb.phase == PH_HDR) begin
        if (sb.phase == PH_HDR)
          send_item(CMD_DATA, 5'($urandom), $urandom,
                    {8'($urandom_range(0, 3)), ($urandom_range(0, 2) == 0) ?
                     8'h80 : 8'h00, 16'($urandom)});
        else send_item(CMD_DATA, 5'($urandom), $urandom, $urandom);
      end else begin
        send_item(CMD_ADVANCE, 5'($urandom), $urandom, $urandom);
        if (sb.phase == PH_IDLE && $urandom_range(0, 1) == 0) break;
      end
      // occasional noise in the middle of a transfer
      if ($urandom_range(0, 9) == 0)
        send_item(2'($urandom), 5'($urandom), $urandom, $urandom);
    end
  endtask

  initial begin
    int ch;
    sb = new();
    sb.reset_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: register extremes, reset values, unmapped indexes
    send_item(CMD_READ, IDX_PRIORITY, 0, 0);
    send_item(CMD_WRITE, IDX_IRQ, 32'hFFFF_FFFF, 0);
    send_item(CMD_READ, IDX_IRQ, 0, 0);
    send_item(CMD_WRITE, IDX_IRQ, 32'h0000_8000, 0);
    send_item(CMD_READ, IDX_IRQ, 0, 0);
    send_item(CMD_WRITE, IDX_PRIORITY, 32'hFFFF_FFFF, 0);
    send_item(CMD_WRITE, 5'd30, 32'hFFFF_FFFF, 0);
    send_item(CMD_READ, 5'd31, 0, 0);
    send_item(CMD_WRITE, 5'd0, 32'hFFFF_FFFF, 0);
    send_item(CMD_WRITE, 5'd3, 32'hFFFF_FFFF, 0);
    send_item(CMD_READ, 5'd0, 0, 0);
    send_item(CMD_READ, 5'd3, 0, 0);
    send_item(CMD_DATA, 5'd31, 0, 32'hFFFF_FFFF);
    send_item(CMD_ADVANCE, 5'd0, 0, 0);
    // OTC channel, two words, then two mode-three starts
    send_item(CMD_WRITE, 5'(OTC_CH*4), 32'h0000_0010, 0);
    send_item(CMD_WRITE, 5'(OTC_CH*4+1), 32'd2, 0);
    send_item(CMD_WRITE, 5'(OTC_CH*4+2), ctrl_word(MODE_BLOCK, 0, 1, 1), 0);
    repeat (3) send_item(CMD_ADVANCE, 5'd0, 0, 0);
    send_item(CMD_WRITE, 5'd1, 32'd0, 0);
    send_item(CMD_WRITE, 5'd2, 32'hFFFF_FFFF, 0);
    send_item(CMD_ADVANCE, 5'd0, 0, 0);
    send_item(CMD_WRITE, 5'd6, ctrl_word(MODE_NONE, 0, 0, 0), 0);
    send_item(CMD_ADVANCE, 5'd0, 0, 0);
    wait_drained();

    // random transfers across channels, with noise
    while (1) begin
      ch = $urandom_range(0, NCH - 1);
      if ($urandom_range(0, 5) == 0)
        repeat (4) send_item(2'($urandom), 5'($urandom), $urandom, $urandom);
      else run_transfer(ch);
      if ($urandom_range(0, 9) == 0) wait_drained();
      if (sb.mismatches > 1000 || items_sent >= ITEM_TARGET) break;
    end
    repeat (200) begin
      if ($urandom_range(0, 1)) run_transfer($urandom_range(0, NCH - 1));
      else send_item(2'($urandom), 5'($urandom), $urandom, $urandom);
      if ($urandom_range(0, 3) != 0) break;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
